[design/ceod_pkg.sv]
// Shared types and constants for the channel energy occupancy detector.
// Used by every module in the design folder; no dependencies of its own.
package ceod_pkg;

  // Default sizing handed to the top-level parameters
  localparam int FFT_POINTS_DEF   = 1024;
  localparam int MAX_CHANNELS_DEF = 16;

  // Field widths
  localparam int SAMP_W   = 16;  // Q1.15 bin component
  localparam int SQ_W     = 31;  // square of a Q1.15 value, at most 2^30
  localparam int PWR_W    = 32;  // re^2 + im^2
  localparam int ACC_W    = 48;  // per-channel energy accumulator
  localparam int MASK_W   = 16;  // occupancy mask port
  localparam int THR_W    = 32;
  localparam int FTA_W    = 8;
  localparam int NCH_W    = 5;
  localparam int BPC_W    = 10;
  localparam int SPAN_W   = NCH_W + BPC_W;          // channels * bins
  localparam int LIMIT1_W = THR_W + BPC_W;          // threshold * bins
  localparam int LIMIT_W  = LIMIT1_W + FTA_W;       // threshold * bins * frames

  // Register port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_FRAMES    = 2'd1,
    REG_CHANNELS  = 2'd2,
    REG_BINS      = 2'd3
  } reg_idx_t;

  // Register reset values (threshold is 0.0015 in Q2.30)
  localparam logic [THR_W-1:0] THRESHOLD_RST = 32'd1610613;
  localparam logic [FTA_W-1:0] FRAMES_RST    = 8'd5;
  localparam logic [NCH_W-1:0] CHANNELS_RST  = 5'd5;
  localparam logic [BPC_W-1:0] BINS_RST      = 10'd102;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [FTA_W-1:0]   frames_to_average;
    logic [NCH_W-1:0]   active_channels;   // already clamped to MAX_CHANNELS
    logic [BPC_W-1:0]   bins_per_channel;
    logic [LIMIT_W-1:0] limit;             // threshold * bins * frames
  } cfg_t;

  // Per-transaction control carried from the front stage to the accumulator stage
  typedef struct packed {
    logic last;     // frame end
    logic decide;   // frame end of a decision frame
    logic acc_en;   // bin lands in an active channel during averaging
  } item_ctrl_t;

endpackage

[design/channel_energy_occupancy_detector_top.sv]
// Channel energy occupancy detector, top level.
// Depends on ceod_pkg, ceod_cfg, ceod_front and ceod_accum.
//
// Usage:
//   Input channel (in_valid / in_stall): one complex FFT bin per transaction,
//   Q1.15 real and imaginary parts in bin order, in_frame_end on the last bin.
//   Bin power is summed per channel; after frames_to_average frames the next
//   frame is skipped and its frame end yields a fresh busy mask.
//   Result channel (out_valid / out_stall): one transaction per frame end,
//   carrying the current mask and a flag for a freshly made decision.
//   Register port: APB-style, four 32-bit registers at byte offsets 0..12.
// Timing:
//   One bin per clock sustained while no result waits under out_stall. A frame
//   end passes the input register, accumulator stage and result register.
//   The busy limit is a two-multiply product with a register after each.
// Stall: while a result waits under out_stall, bins without a frame end keep
//   flowing; a frame end halts in the accumulator stage and in_stall rises
//   once the input register fills behind it.
// Reset: synchronous, active low; registers go to defaults, accumulators,
//   counters and the mask clear, and both pipeline stages empty.
module channel_energy_occupancy_detector_top import ceod_pkg::*; #(
  parameter int FFT_POINTS   = FFT_POINTS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [SAMP_W-1:0] in_bin_real,
  input  logic signed [SAMP_W-1:0] in_bin_imag,
  input  logic                     in_frame_end,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [MASK_W-1:0]        out_occupancy_mask,
  output logic                     out_decision_fresh,
  // register port
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [ADDR_W-1:0]        cfg_paddr,
  input  logic [DATA_W-1:0]        cfg_pwdata,
  output logic [DATA_W-1:0]        cfg_prdata,
  output logic                     cfg_pready
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  cfg_t            cfg;
  logic            s2_ready, s2_load;
  item_ctrl_t      s2_ctrl;
  logic [CH_W-1:0] s2_ch;
  logic [SQ_W-1:0] s2_sq_re, s2_sq_im;

  ceod_cfg #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ceod_front #(
    .FFT_POINTS  (FFT_POINTS),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_bin_real (in_bin_real),
    .in_bin_imag (in_bin_imag),
    .in_frame_end(in_frame_end),
    .s2_ready    (s2_ready),
    .s2_load     (s2_load),
    .s2_ctrl     (s2_ctrl),
    .s2_ch       (s2_ch),
    .s2_sq_re    (s2_sq_re),
    .s2_sq_im    (s2_sq_im)
  );

  ceod_accum #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_accum (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .s2_load           (s2_load),
    .s2_ready          (s2_ready),
    .s2_ctrl           (s2_ctrl),
    .s2_ch             (s2_ch),
    .s2_sq_re          (s2_sq_re),
    .s2_sq_im          (s2_sq_im),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_occupancy_mask(out_occupancy_mask),
    .out_decision_fresh(out_decision_fresh)
  );

endmodule

[design/ceod_cfg.sv]
// Configuration register bank with APB-style access and the busy limit product.
// Depends on ceod_pkg.
module ceod_cfg import ceod_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  logic [THR_W-1:0]    threshold_r;
  logic [FTA_W-1:0]    frames_r;
  logic [NCH_W-1:0]    channels_r;
  logic [BPC_W-1:0]    bins_r;
  logic [LIMIT1_W-1:0] limit1_r;
  logic [LIMIT_W-1:0]  limit_r;
  reg_idx_t            idx;
  logic                wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      frames_r    <= FRAMES_RST;
      channels_r  <= CHANNELS_RST;
      bins_r      <= BINS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_THRESHOLD: threshold_r <= cfg_pwdata[THR_W-1:0];
        REG_FRAMES:    frames_r    <= cfg_pwdata[FTA_W-1:0];
        REG_CHANNELS:  channels_r  <= cfg_pwdata[NCH_W-1:0];
        REG_BINS:      bins_r      <= cfg_pwdata[BPC_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_THRESHOLD: cfg_prdata = DATA_W'(threshold_r);
      REG_FRAMES:    cfg_prdata = DATA_W'(frames_r);
      REG_CHANNELS:  cfg_prdata = DATA_W'(channels_r);
      REG_BINS:      cfg_prdata = DATA_W'(bins_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Limit = threshold * bins * frames, two multiplies with a register between
  always_ff @(posedge clk) begin
    limit1_r <= LIMIT1_W'(threshold_r) * LIMIT1_W'(bins_r);
    limit_r  <= LIMIT_W'(limit1_r) * LIMIT_W'(frames_r);
  end

  // Clamp channel count to what the hardware holds
  always_comb begin
    cfg.frames_to_average = frames_r;
    cfg.bins_per_channel  = bins_r;
    cfg.limit             = limit_r;
    if (channels_r > NCH_W'(MAX_CHANNELS)) begin
      cfg.active_channels = NCH_W'(MAX_CHANNELS);
    end else begin
      cfg.active_channels = channels_r;
    end
  end

endmodule

[design/ceod_front.sv]
// Input register stage: bin position and frame tracking, channel lookup, bin squares.
// Depends on ceod_pkg; feeds ceod_accum.
module ceod_front import ceod_pkg::*; #(
  parameter int FFT_POINTS   = FFT_POINTS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int POS_W = $clog2(FFT_POINTS),
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [SAMP_W-1:0] in_bin_real,
  input  logic signed [SAMP_W-1:0] in_bin_imag,
  input  logic                     in_frame_end,
  input  logic                     s2_ready,
  output logic                     s2_load,
  output item_ctrl_t               s2_ctrl,
  output logic [CH_W-1:0]          s2_ch,
  output logic [SQ_W-1:0]          s2_sq_re,
  output logic [SQ_W-1:0]          s2_sq_im
);

  logic                     s1_valid_r, s1_valid_nxt;
  logic signed [SAMP_W-1:0] s1_re_r, s1_im_r;
  logic                     s1_last_r;
  logic [POS_W-1:0]         bin_position_r, bin_position_nxt;
  logic [FTA_W-1:0]         frames_done_r, frames_done_nxt;
  logic                     accept;
  logic                     avg_phase;
  logic [SPAN_W-1:0]        pos_ext, span;
  logic [MAX_CHANNELS-1:0]  ge;
  logic signed [2*SAMP_W-1:0] prod_re, prod_im;

  // Handshake: s1 is free when empty or moving on
  assign s2_load  = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Input payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_re_r   <= in_bin_real;
      s1_im_r   <= in_bin_imag;
      s1_last_r <= in_frame_end;
    end
  end

  // Channel of the current bin: count channel boundaries at or below it
  assign pos_ext = SPAN_W'(bin_position_r);
  always_comb begin
    ge[0] = 1'b0;
    for (int c = 1; c < MAX_CHANNELS; c++) begin
      ge[c] = pos_ext >= (SPAN_W'(c) * SPAN_W'(cfg.bins_per_channel));
    end
  end
  assign span      = SPAN_W'(cfg.active_channels) * SPAN_W'(cfg.bins_per_channel);
  assign avg_phase = frames_done_r < cfg.frames_to_average;
  assign s2_ch     = CH_W'($countones(ge));

  always_comb begin
    s2_ctrl.last   = s1_last_r;
    s2_ctrl.decide = s1_last_r && !avg_phase;
    s2_ctrl.acc_en = avg_phase && (pos_ext < span);
  end

  // Bin power terms
  assign prod_re  = s1_re_r * s1_re_r;
  assign prod_im  = s1_im_r * s1_im_r;
  assign s2_sq_re = prod_re[SQ_W-1:0];
  assign s2_sq_im = prod_im[SQ_W-1:0];

  // Position within frame (saturating) and averaging frame count
  always_comb begin
    bin_position_nxt = bin_position_r;
    frames_done_nxt  = frames_done_r;
    if (s1_last_r) begin
      bin_position_nxt = '0;
      frames_done_nxt  = avg_phase ? frames_done_r + 1'b1 : '0;
    end else if (bin_position_r < POS_W'(FFT_POINTS - 1)) begin
      bin_position_nxt = bin_position_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_position_r <= '0;
      frames_done_r  <= '0;
    end else if (s2_load) begin
      bin_position_r <= bin_position_nxt;
      frames_done_r  <= frames_done_nxt;
    end
  end

endmodule

[design/ceod_accum.sv]
// Accumulator stage: per-channel energy sums, busy decision and result register.
// Depends on ceod_pkg; fed by ceod_front.
module ceod_accum import ceod_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              s2_load,
  output logic              s2_ready,
  input  item_ctrl_t        s2_ctrl,
  input  logic [CH_W-1:0]   s2_ch,
  input  logic [SQ_W-1:0]   s2_sq_re,
  input  logic [SQ_W-1:0]   s2_sq_im,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MASK_W-1:0] out_occupancy_mask,
  output logic              out_decision_fresh
);

  logic                    s2_valid_r, s2_valid_nxt;
  item_ctrl_t              ctrl_r;
  logic [CH_W-1:0]         ch_r;
  logic [SQ_W-1:0]         sq_re_r, sq_im_r;
  logic [ACC_W-1:0]        energy_r [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] busy_mask_r, new_mask;
  logic                    out_valid_r;
  logic [MASK_W-1:0]       out_mask_r;
  logic                    out_fresh_r;
  logic                    out_free, retire;
  logic [PWR_W-1:0]        power;
  logic [ACC_W:0]          sum;
  logic [ACC_W-1:0]        sat_sum;

  // Frame-end transactions wait for the result register, others pass freely
  assign out_free = !out_valid_r || !out_stall;
  assign retire   = s2_valid_r && (!ctrl_r.last || out_free);
  assign s2_ready = !s2_valid_r || retire;

  always_comb begin
    if (s2_load) begin
      s2_valid_nxt = 1'b1;
    end else if (retire) begin
      s2_valid_nxt = 1'b0;
    end else begin
      s2_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      ctrl_r  <= s2_ctrl;
      ch_r    <= s2_ch;
      sq_re_r <= s2_sq_re;
      sq_im_r <= s2_sq_im;
    end
  end

  // Saturating accumulate of bin power
  assign power   = PWR_W'(sq_re_r) + PWR_W'(sq_im_r);
  assign sum     = {1'b0, energy_r[ch_r]} + (ACC_W + 1)'(power);
  assign sat_sum = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];

  // Busy when 2*sum exceeds the limit, active channels only
  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      new_mask[c] = (NCH_W'(c) < cfg.active_channels) &&
                    (LIMIT_W'({energy_r[c], 1'b0}) > cfg.limit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        energy_r[c] <= '0;
      end
      busy_mask_r <= '0;
    end else if (retire && ctrl_r.decide) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        energy_r[c] <= '0;
      end
      busy_mask_r <= new_mask;
    end else if (retire && ctrl_r.acc_en) begin
      energy_r[ch_r] <= sat_sum;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (retire && ctrl_r.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire && ctrl_r.last) begin
      out_mask_r  <= MASK_W'(ctrl_r.decide ? new_mask : busy_mask_r);
      out_fresh_r <= ctrl_r.decide;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_occupancy_mask = out_mask_r;
  assign out_decision_fresh = out_fresh_r;

endmodule

[verif/tb_channel_energy_occupancy_detector_top.sv]
// Self-checking testbench for channel_energy_occupancy_detector_top.
// Drives FFT bins and APB register writes, and checks every occupancy result against
// an in-bench predictor of the detector or a typed value. Needs ceod_pkg and the design files.
`timescale 1ns / 1ps

module tb_channel_energy_occupancy_detector_top;
  import ceod_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [63:0] ACC_FULL = (64'd1 << ACC_W) - 64'd1;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef enum logic [1:0] {
    FRAMES_RANDOM,  // random lengths, per-channel power levels
    FRAMES_LONG,    // frames past FFT_POINTS, loud bins only past the end
    FRAMES_FLOOD    // full-scale bins at every position
  } frame_kind_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              fresh;
  } occ_result_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] re;
    logic signed [SAMP_W-1:0] im;
    logic                     fe;
    logic                     typed;  // result written out below, not predicted
    logic [MASK_W-1:0]        mask;
    logic                     fresh;
  } bin_row_t;

  typedef struct packed {
    logic [THR_W-1:0] thr;
    logic [FTA_W-1:0] fta;
    logic [NCH_W-1:0] nch;
    logic [BPC_W-1:0] bpc;
    idle_mode_t       idle;
    frame_kind_t      kind;
    int unsigned      frames;
    int unsigned      max_len;
  } phase_cfg_t;

  // Directed bins under the reset configuration (5 frames averaged, 102 bins per channel)
  localparam bin_row_t DIRECTED [14] = '{
    '{16'sh7FFF, 16'sh0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'sh8000, 16'sh8000, 1'b1, 1'b1, 16'h0000, 1'b0},  // first frame end after reset
    '{16'sh0000, 16'sh0000, 1'b1, 1'b1, 16'h0000, 1'b0},
    '{16'shFFFF, 16'sh0001, 1'b1, 1'b1, 16'h0000, 1'b0},
    '{16'sh8000, 16'sh7FFF, 1'b1, 1'b1, 16'h0000, 1'b0},
    '{16'sh5555, 16'shAAAA, 1'b1, 1'b1, 16'h0000, 1'b0},
    '{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},  // decision frame, ignored
    '{16'sh0000, 16'sh0000, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'sh0000, 16'sh0000, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'sh0000, 16'sh0000, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'sh0000, 16'sh0000, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'sh0000, 16'sh0000, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'sh0000, 16'sh0000, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'sh0000, 16'sh0000, 1'b1, 1'b1, 16'h0000, 1'b1}   // silent frames: nothing busy
  };

  // Register settings and traffic per phase
  localparam int NUM_PHASES = 11;
  localparam phase_cfg_t PHASES [NUM_PHASES] = '{
    '{32'd1 << 20,  8'd1,   5'd4,  10'd3,    IDLE_NONE,     FRAMES_RANDOM, 8,   16},
    '{32'd1 << 22,  8'd2,   5'd16, 10'd1,    IDLE_SENDER,   FRAMES_RANDOM, 8,   10},
    '{32'd1 << 18,  8'd3,   5'd31, 10'd2,    IDLE_RECEIVER, FRAMES_RANDOM, 6,   20},
    '{32'd0,        8'd0,   5'd8,  10'd2,    IDLE_BOTH,     FRAMES_RANDOM, 8,   10},
    '{32'hFFFFFFFF, 8'd1,   5'd0,  10'd4,    IDLE_NONE,     FRAMES_RANDOM, 6,   8},
    '{32'd1 << 16,  8'd2,   5'd3,  10'd0,    IDLE_SENDER,   FRAMES_RANDOM, 6,   8},
    '{32'd1 << 24,  8'd1,   5'd1,  10'd1023, IDLE_RECEIVER, FRAMES_RANDOM, 6,   16},
    '{32'd1 << 21,  8'd100, 5'd16, 10'd1,    IDLE_BOTH,     FRAMES_RANDOM, 102, 1},
    '{32'd1 << 19,  8'd4,   5'd6,  10'd5,    IDLE_NONE,     FRAMES_RANDOM, 6,   20},
    // one long averaging frame; the next phase opens with its decision
    '{32'd1 << 20,  8'd1,   5'd16, 10'd64,   IDLE_RECEIVER, FRAMES_LONG,   1,   0},
    '{32'd1 << 20,  8'd1,   5'd16, 10'd64,   IDLE_BOTH,     FRAMES_FLOOD,  4,   8}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [SAMP_W-1:0] in_bin_real = '0;
  logic signed [SAMP_W-1:0] in_bin_imag = '0;
  logic                     in_frame_end = 1'b0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [MASK_W-1:0]        out_occupancy_mask;
  logic                     out_decision_fresh;

  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]        cfg_paddr = '0;
  logic [DATA_W-1:0]        cfg_pwdata = '0;
  logic [DATA_W-1:0]        cfg_prdata;
  logic                     cfg_pready;

  // Register mirror
  logic [THR_W-1:0] cfg_thr = THRESHOLD_RST;
  logic [FTA_W-1:0] cfg_fta = FRAMES_RST;
  logic [NCH_W-1:0] cfg_nch = CHANNELS_RST;
  logic [BPC_W-1:0] cfg_bpc = BINS_RST;

  // Predicted detector state
  logic [BPC_W-1:0] bin_pos = '0;
  logic [FTA_W-1:0] frames_done = '0;
  logic [ACC_W-1:0] acc_energy [MAX_CHANNELS_DEF];
  logic [MASK_W-1:0] busy_mask = '0;

  occ_result_t occupancy_expected [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned chan_shift [MAX_CHANNELS_DEF];

  channel_energy_occupancy_detector_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_bin_real        (in_bin_real),
    .in_bin_imag        (in_bin_imag),
    .in_frame_end       (in_frame_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_occupancy_mask (out_occupancy_mask),
    .out_decision_fresh (out_decision_fresh),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always #2 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_channel_energy_occupancy_detector_top: FAIL");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    occ_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (occupancy_expected.size() == 0) begin
        $display("%0t: unexpected result: mask %h fresh %b", $time,
                 out_occupancy_mask, out_decision_fresh);
        fail_count++;
      end else begin
        want = occupancy_expected.pop_front();
        if (out_occupancy_mask !== want.mask) begin
          $display("%0t: occupancy_mask expected %h actual %h", $time,
                   want.mask, out_occupancy_mask);
          fail_count++;
        end
        if (out_decision_fresh !== want.fresh) begin
          $display("%0t: decision_fresh expected %b actual %b", $time,
                   want.fresh, out_decision_fresh);
          fail_count++;
        end
      end
    end
  end

  // Energy detector behavior for one accepted bin
  task automatic predict_occupancy(input logic signed [SAMP_W-1:0] re,
                                   input logic signed [SAMP_W-1:0] im,
                                   input logic fe, output occ_result_t res);
    int unsigned nch;
    int unsigned ch;
    longint      r;
    longint      i;
    logic [63:0] sum;
    logic [63:0] limit;
    logic [MASK_W-1:0] mask;
    nch = (cfg_nch > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : cfg_nch;
    res = '0;
    // accumulate while averaging, only bins inside the active channels
    if (frames_done < cfg_fta && cfg_bpc != 0) begin
      ch = bin_pos / cfg_bpc;
      if (ch < nch) begin
        r = re;
        i = im;
        sum = 64'(acc_energy[ch]) + 64'(r * r + i * i);
        acc_energy[ch] = (sum > ACC_FULL) ? ACC_FULL[ACC_W-1:0] : sum[ACC_W-1:0];
      end
    end
    if (!fe) begin
      if (bin_pos < FFT_POINTS_DEF - 1) bin_pos++;
      return;
    end
    bin_pos = '0;
    if (frames_done < cfg_fta) begin
      frames_done++;
      res = '{mask: busy_mask, fresh: 1'b0};
      return;
    end
    // decision frame end: compare and clear
    limit = 64'(cfg_thr) * 64'(cfg_bpc) * 64'(cfg_fta);
    mask = '0;
    for (int c = 0; c < MAX_CHANNELS_DEF; c++) begin
      if (c < nch && (64'(acc_energy[c]) << 1) > limit) mask[c] = 1'b1;
      acc_energy[c] = '0;
    end
    busy_mask = mask;
    frames_done = '0;
    res = '{mask: busy_mask, fresh: 1'b1};
  endtask

  function automatic void set_idle(idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = 46;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct = 46;
      end
      IDLE_BOTH: begin
        send_idle_pct = 14;
        stall_pct = 14;
      end
      default: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
    endcase
  endfunction

  // One bin transaction; returns at the edge that accepts it
  task automatic push_bin(input logic signed [SAMP_W-1:0] re,
                          input logic signed [SAMP_W-1:0] im, input logic fe,
                          input logic typed, input occ_result_t typed_res);
    occ_result_t res;
    occ_result_t exp_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_bin_real  <= re;
    in_bin_imag  <= im;
    in_frame_end <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_occupancy(re, im, fe, res);
    if (fe) begin
      exp_res = typed ? typed_res : res;
      occupancy_expected = {occupancy_expected, exp_res};
    end
  endtask

  // Wait out every expected result plus pipeline latency
  task automatic settle();
    in_valid <= 1'b0;
    while (occupancy_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(int'(idx) * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_THRESHOLD: cfg_thr = value[THR_W-1:0];
      REG_FRAMES:    cfg_fta = value[FTA_W-1:0];
      REG_CHANNELS:  cfg_nch = value[NCH_W-1:0];
      REG_BINS:      cfg_bpc = value[BPC_W-1:0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic signed [SAMP_W-1:0] scaled_component(int unsigned shift);
    logic signed [SAMP_W-1:0] raw;
    raw = SAMP_W'($urandom);
    return raw >>> shift;
  endfunction

  function automatic logic signed [SAMP_W-1:0] draw_component(int unsigned shift);
    case ($urandom_range(15))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return scaled_component(shift);
    endcase
  endfunction

  task automatic send_frame(input phase_cfg_t ph);
    int unsigned len;
    int unsigned ch;
    logic signed [SAMP_W-1:0] re;
    logic signed [SAMP_W-1:0] im;
    occ_result_t none;
    none = '0;
    case (ph.kind)
      FRAMES_LONG:  len = FFT_POINTS_DEF + 16;
      FRAMES_FLOOD: len = ph.max_len;
      default:      len = $urandom_range(ph.max_len, 1);
    endcase
    for (int unsigned n = 0; n < len; n++) begin
      ch = (ph.bpc == 0) ? 0 : n / ph.bpc;
      if (ch >= MAX_CHANNELS_DEF) ch = MAX_CHANNELS_DEF - 1;
      case (ph.kind)
        FRAMES_FLOOD: begin
          re = 16'sh8000;
          im = 16'sh8000;
        end
        FRAMES_LONG: begin
          // near-silent inside the frame, loud once the position pins
          re = scaled_component(n < FFT_POINTS_DEF ? 14 : 0);
          im = scaled_component(n < FFT_POINTS_DEF ? 14 : 0);
        end
        default: begin
          re = draw_component(chan_shift[ch]);
          im = draw_component(chan_shift[ch]);
        end
      endcase
      push_bin(re, im, n == len - 1, 1'b0, none);
    end
    // move channel power levels now and then
    for (int c = 0; c < MAX_CHANNELS_DEF; c++) begin
      if ($urandom_range(2) == 0) chan_shift[c] = $urandom_range(12);
    end
  endtask

  initial begin
    for (int c = 0; c < MAX_CHANNELS_DEF; c++) begin
      acc_energy[c] = '0;
      chan_shift[c] = $urandom_range(12);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed bins under reset register values
    set_idle(IDLE_NONE);
    foreach (DIRECTED[k]) begin
      push_bin(DIRECTED[k].re, DIRECTED[k].im, DIRECTED[k].fe, DIRECTED[k].typed,
               '{mask: DIRECTED[k].mask, fresh: DIRECTED[k].fresh});
    end

    // random traffic, one register setting per phase
    foreach (PHASES[p]) begin
      settle();
      set_idle(IDLE_NONE);
      write_reg(REG_THRESHOLD, DATA_W'(PHASES[p].thr));
      write_reg(REG_FRAMES, DATA_W'(PHASES[p].fta));
      write_reg(REG_CHANNELS, DATA_W'(PHASES[p].nch));
      write_reg(REG_BINS, DATA_W'(PHASES[p].bpc));
      settle();
      set_idle(PHASES[p].idle);
      repeat (PHASES[p].frames) send_frame(PHASES[p]);
    end

    settle();
    if (fail_count == 0) begin
      $display("tb_channel_energy_occupancy_detector_top: PASS");
    end else begin
      $display("tb_channel_energy_occupancy_detector_top: FAIL");
    end
    $finish;
  end

endmodule
